// ----- sv/mbps_pkg.sv -----
// Shared types and constants of the masked byte pattern scanner.
`timescale 1ns / 1ps
package mbps_pkg;

   localparam int ADDR_W      = 64;
   localparam int CSR_W       = 64;
   localparam int CSR_IDX_W   = 3;
   localparam int LENGTH_W    = 5;
   localparam int LANE_SLOTS  = 16;
   localparam int LANES_W     = 8 * LANE_SLOTS;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LOW    = 3'd0,
      CSR_PATTERN_HIGH   = 3'd1,
      CSR_MASK_LOW       = 3'd2,
      CSR_MASK_HIGH      = 3'd3,
      CSR_PATTERN_LENGTH = 3'd4,
      CSR_BASE_ADDRESS   = 3'd5
   } mbps_csr_type;

   // Match setup handed to the front end.
   typedef struct packed {
      logic [LANES_W-1:0]  pattern;
      logic [LANES_W-1:0]  mask;
      logic [LENGTH_W-1:0] length;
   } mbps_match_cfg_type;

   // One queued result: found flag and offset of the first matching byte.
   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] offset;
   } mbps_entry_type;

   // Handshake between a producer and the queue.
   typedef struct packed {
      logic           push;
      mbps_entry_type entry;
   } mbps_push_type;

   typedef struct packed {
      logic           valid;
      mbps_entry_type entry;
   } mbps_head_type;

endpackage

// ----- sv/mbps_front.sv -----
// Front end: byte window, masked compare and scan control.
`timescale 1ns / 1ps
module mbps_front #(
   parameter int MAX_PATTERN = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [7:0]                  data_byte,
   input  logic                        last_byte,
   input  logic                        read_error,
   input  mbps_pkg::mbps_match_cfg_type cfg,
   output mbps_pkg::mbps_push_type     push_out
);
   import mbps_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W = $clog2(MAX_PATTERN);

   logic [7:0]        window_ff [MAX_PATTERN];
   logic [7:0]        window_in [MAX_PATTERN];
   logic [LEN_W-1:0]  fill_ff, fill_in, fill_next;
   logic [ADDR_W-1:0] offset_ff, offset_in;
   logic              finished_ff, finished_in;

   logic [LEN_W-1:0]       len, len_m1;
   logic [MAX_PATTERN-1:0] lane_ok;
   logic                   match;

   // Clamp the configured length to 1..MAX_PATTERN.
   always_comb begin
      if (cfg.length == '0) begin
         len = LEN_W'(1);
      end else if (cfg.length > LENGTH_W'(MAX_PATTERN)) begin
         len = LEN_W'(MAX_PATTERN);
      end else begin
         len = cfg.length[LEN_W-1:0];
      end
      len_m1 = len - LEN_W'(1);
   end

   // Window with the new byte shifted in, newest at slot 0.
   always_comb begin
      window_in[0] = data_byte;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         window_in[k] = window_ff[k-1];
      end
      fill_next = (fill_ff == LEN_W'(MAX_PATTERN)) ? fill_ff : fill_ff + LEN_W'(1);
   end

   // Pattern lane i lines up with window slot len-1-i.
   always_comb begin
      logic [LEN_W-1:0] slot;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         slot = len_m1 - LEN_W'(i);
         lane_ok[i] = (LEN_W'(i) >= len) ||
                      ((window_in[slot[IDX_W-1:0]] & cfg.mask[8*i +: 8])
                       == cfg.pattern[8*i +: 8]);
      end
      match = (fill_next >= len) && (&lane_ok);
   end

   always_comb begin
      fill_in        = fill_ff;
      offset_in      = offset_ff;
      finished_in    = finished_ff;
      push_out.push  = 1'b0;
      push_out.entry = '0;
      if (accept) begin
         priority if (finished_ff) begin
            if (last_byte) begin
               fill_in     = '0;
               offset_in   = '0;
               finished_in = 1'b0;
            end
         end else if (read_error) begin
            push_out.push = 1'b1;
            if (last_byte) begin
               fill_in   = '0;
               offset_in = '0;
            end else begin
               finished_in = 1'b1;
            end
         end else if (match) begin
            push_out.push         = 1'b1;
            push_out.entry.found  = 1'b1;
            push_out.entry.offset = offset_ff - ADDR_W'(len_m1);
            if (last_byte) begin
               fill_in   = '0;
               offset_in = '0;
            end else begin
               fill_in     = fill_next;
               finished_in = 1'b1;
            end
         end else if (last_byte) begin
            push_out.push = 1'b1;
            fill_in       = '0;
            offset_in     = '0;
         end else begin
            fill_in   = fill_next;
            offset_in = offset_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         offset_ff   <= '0;
         finished_ff <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         offset_ff   <= offset_in;
         finished_ff <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !finished_ff && !read_error) begin
         window_ff <= window_in;
      end
   end

endmodule

// ----- sv/mbps_queue.sv -----
// Two-entry result queue between front end and back end.
`timescale 1ns / 1ps
module mbps_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  mbps_pkg::mbps_push_type push_in,
   input  logic                    pop,
   output mbps_pkg::mbps_head_type head,
   output logic                    full
);
   import mbps_pkg::*;

   mbps_entry_type         store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   logic do_pop;

   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.entry = store_ff[rd_ptr_ff];
   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_in.push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      unique case ({push_in.push, do_pop})
         2'b10:   count_in = count_ff + QUEUE_CNT_W'(1);
         2'b01:   count_in = count_ff - QUEUE_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         store_ff[wr_ptr_ff] <= push_in.entry;
      end
   end

endmodule

// ----- sv/mbps_back.sv -----
// Back end: address formation and the result output register.
`timescale 1ns / 1ps
module mbps_back (
   input  logic                          clock,
   input  logic                          reset,
   input  mbps_pkg::mbps_head_type       head,
   input  logic [mbps_pkg::ADDR_W-1:0]   base_address,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mbps_pkg::ADDR_W-1:0]   rsp_tdata,
   output logic                          rsp_tuser
);
   import mbps_pkg::*;

   logic              valid_ff, valid_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              found_ff, found_in;

   assign pop = head.valid && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff;
      addr_in  = addr_ff;
      found_in = found_ff;
      if (pop) begin
         valid_in = 1'b1;
         found_in = head.entry.found;
         addr_in  = head.entry.found ? base_address + head.entry.offset : '0;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      found_ff <= found_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = addr_ff;
   assign rsp_tuser  = found_ff;

endmodule

// ----- sv/masked_byte_pattern_scanner.sv -----
// Top level of the masked byte pattern scanner: registers and block wiring.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tdata=data_byte, tlast=last_byte, tuser=read_error
//   rsp      out  rsp_tvalid/rsp_tready  tdata=match_address, tuser=found
//   csr      in   csr_we                 csr_index, csr_wdata (no read-back)
//
// One byte word is taken every cycle while a queue slot is free; the front end compares
// the shifted window against all pattern lanes in the cycle the byte arrives.
// A result passes the queue, then the output register, on its way to rsp; the 64-bit
// base add sits in the back end.
// Synchronous active-high reset clears scan state, queue and output valid, and
// loads the register defaults (pattern_length 1, all else 0).
// req_tready drops only while the two-entry result queue is full, which
// happens when rsp is stalled and results keep coming.
`timescale 1ns / 1ps
module masked_byte_pattern_scanner #(
   parameter int MAX_PATTERN = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // input byte stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] data_byte
   input  logic                            req_tlast,
   input  logic                            req_tuser,   // [0] read_error
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mbps_pkg::ADDR_W-1:0]     rsp_tdata,   // [63:0] match_address
   output logic                            rsp_tuser,   // [0] found
   // configuration writes
   input  logic                            csr_we,
   input  logic [mbps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mbps_pkg::CSR_W-1:0]      csr_wdata
);
   import mbps_pkg::*;

   logic [CSR_W-1:0]    pattern_low_ff, pattern_high_ff;
   logic [CSR_W-1:0]    mask_low_ff, mask_high_ff;
   logic [LENGTH_W-1:0] length_ff;
   logic [ADDR_W-1:0]   base_ff;

   mbps_match_cfg_type match_cfg;
   mbps_push_type      push;
   mbps_head_type      head;
   logic               queue_full;
   logic               queue_pop;
   logic               accept;

   // Register file: write only, unknown indexes drop the write.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         mask_low_ff     <= '0;
         mask_high_ff    <= '0;
         length_ff       <= LENGTH_W'(1);
         base_ff         <= '0;
      end else if (csr_we) begin
         unique case (mbps_csr_type'(csr_index))
            CSR_PATTERN_LOW:    pattern_low_ff  <= csr_wdata;
            CSR_PATTERN_HIGH:   pattern_high_ff <= csr_wdata;
            CSR_MASK_LOW:       mask_low_ff     <= csr_wdata;
            CSR_MASK_HIGH:      mask_high_ff    <= csr_wdata;
            CSR_PATTERN_LENGTH: length_ff       <= csr_wdata[LENGTH_W-1:0];
            CSR_BASE_ADDRESS:   base_ff         <= csr_wdata;
            default:            ;
         endcase
      end
   end

   // Lane i of pattern and mask sits in bits 8i+7:8i.
   assign match_cfg.pattern = {pattern_high_ff, pattern_low_ff};
   assign match_cfg.mask    = {mask_high_ff, mask_low_ff};
   assign match_cfg.length  = length_ff;

   // Hold off input only while no queue slot is free.
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   mbps_front #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_tdata),
      .last_byte  (req_tlast),
      .read_error (req_tuser),
      .cfg        (match_cfg),
      .push_out   (push)
   );

   mbps_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (queue_pop),
      .head    (head),
      .full    (queue_full)
   );

   mbps_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .base_address (base_ff),
      .pop          (queue_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

// ----- sim/tb.sv -----
// Testbench for the masked byte pattern scanner: a directed table, then random byte ranges.
`timescale 1ns / 1ps
module tb;
   import mbps_pkg::*;

   localparam int HALF_HIGH     = 6;
   localparam int HALF_LOW      = 6;
   localparam int RESET_CYCLES  = 12;
   localparam int RANDOM_BYTES  = 1150;
   // result path is queue plus output register; let a byte with no result leave the pipe
   localparam int DRAIN_CYCLES  = 6;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SCAN_SLOTS    = LANE_SLOTS;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;
   localparam logic [63:0] ALL_ONES = '1;

   typedef enum logic {ROW_BYTE, ROW_REG} row_kind_type;

   // one line of the directed table: a byte word or a register write
   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] index;
      logic [63:0]          value;
      logic [7:0]           data;
      logic                 last;
      logic                 err;
      logic                 typed;    // expected result written in the table
      logic                 hit;      // a result is expected at all
      logic                 found;
      logic [63:0]          addr;
   } plan_row_type;

   typedef struct packed {
      logic        found;
      logic [63:0] addr;
   } scan_report_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;
   logic                 req_tlast  = 1'b0;
   logic                 req_tuser  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [ADDR_W-1:0]    rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CSR_W-1:0]     csr_wdata  = '0;

   masked_byte_pattern_scanner DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] data_byte
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),    // [0] read_error
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [63:0] match_address
      .rsp_tuser  (rsp_tuser),    // [0] found
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #(HALF_LOW) clock = 1'b1;
      #(HALF_HIGH) clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Scanner prediction: register copies, sliding window and range bookkeeping.
   // ---------------------------------------------------------------------------------------
   logic [63:0]  pat_lo, pat_hi, msk_lo, msk_hi, base_addr;
   logic [4:0]   pat_len;
   logic [7:0]   recent [SCAN_SLOTS];   // newest byte at slot 0
   int unsigned  recent_fill;
   logic [63:0]  range_offset;
   bit           range_done;            // result already given for this range

   scan_report_type awaited_reports [$];
   plan_row_type    plan [$];
   int unsigned     fail_count  = 0;
   int unsigned     sent_bytes  = 0;
   int unsigned     cycle_count = 0;
   bit              sender_steady = 1'b0;

   function automatic void restart_range();
      foreach (recent[k]) recent[k] = '0;
      recent_fill  = 0;
      range_offset = '0;
      range_done   = 1'b0;
   endfunction

   // length 0 behaves as 1, anything above the window size as the window size
   function automatic int unsigned live_length();
      if (pat_len == 0) return 1;
      if (pat_len > SCAN_SLOTS) return SCAN_SLOTS;
      return pat_len;
   endfunction

   function automatic bit window_hit(int unsigned n);
      logic [127:0] pat;
      logic [127:0] msk;
      pat = {pat_hi, pat_lo};
      msk = {msk_hi, msk_lo};
      if (recent_fill < n) return 1'b0;
      // oldest byte of the window lines up with pattern lane 0
      for (int i = 0; i < n; i++)
         if ((recent[n - 1 - i] & msk[i*8 +: 8]) != pat[i*8 +: 8]) return 1'b0;
      return 1'b1;
   endfunction

   // advance the scan by one byte word; returns 1 when the byte yields a result
   function automatic bit scan_byte(input logic [7:0] data, input bit last, input bit err,
                                    output scan_report_type rep);
      int unsigned n;
      n   = live_length();
      rep = '0;
      if (range_done) begin
         if (last) restart_range();
         return 1'b0;
      end
      if (err) begin
         if (last) restart_range();
         else range_done = 1'b1;
         return 1'b1;
      end
      for (int k = SCAN_SLOTS - 1; k > 0; k--) recent[k] = recent[k - 1];
      recent[0] = data;
      if (recent_fill < SCAN_SLOTS) recent_fill++;
      if (window_hit(n)) begin
         rep.found = 1'b1;
         rep.addr  = base_addr + range_offset - 64'(n - 1);
         if (last) restart_range();
         else range_done = 1'b1;
         return 1'b1;
      end
      range_offset++;
      if (last) begin
         restart_range();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // mostly back to back, sometimes a short hold, rarely a long hold
   function automatic int unsigned idle_span();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void plan_byte(logic [7:0] data, bit last, bit err);
      plan_row_type row;
      row      = '0;
      row.kind = ROW_BYTE;
      row.data = data;
      row.last = last;
      row.err  = err;
      plan.push_back(row);
   endfunction

   function automatic void plan_known(logic [7:0] data, bit last, bit err,
                                      bit hit, bit found, logic [63:0] addr);
      plan_row_type row;
      row       = '0;
      row.kind  = ROW_BYTE;
      row.data  = data;
      row.last  = last;
      row.err   = err;
      row.typed = 1'b1;
      row.hit   = hit;
      row.found = found;
      row.addr  = addr;
      plan.push_back(row);
   endfunction

   function automatic void plan_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] value);
      plan_row_type row;
      row       = '0;
      row.kind  = ROW_REG;
      row.index = idx;
      row.value = value;
      plan.push_back(row);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Byte sender: optional hold-off, then present the word until the scanner takes it.
   // On acceptance, advance the prediction and queue whatever result the byte causes.
   // ---------------------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] data, input bit last, input bit err,
                            input bit typed, input bit t_hit, input bit t_found,
                            input logic [63:0] t_addr);
      int unsigned     gap;
      scan_report_type rep;
      bit              hit;
      if (csr_we) csr_we <= 1'b0;
      gap = sender_steady ? 0 : idle_span();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      req_tuser  <= err;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      hit = scan_byte(data, last, err, rep);
      if (typed) begin
         hit       = t_hit;
         rep.found = t_found;
         rep.addr  = t_addr;
      end
      if (hit) awaited_reports.push_back(rep);
      sent_bytes++;
   endtask

   // Register write: only from an idle scanner. The first of a group of writes drops the
   // byte stream, waits for every outstanding result and lets the pipe empty.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      if (!csr_we) begin
         req_tvalid <= 1'b0;
         while (awaited_reports.size() != 0) @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
      end
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_PATTERN_LOW:    pat_lo    = value;
         CSR_PATTERN_HIGH:   pat_hi    = value;
         CSR_MASK_LOW:       msk_lo    = value;
         CSR_MASK_HIGH:      msk_hi    = value;
         CSR_PATTERN_LENGTH: pat_len   = value[4:0];
         CSR_BASE_ADDRESS:   base_addr = value;
         default: ;          // unknown index: dropped by the block
      endcase
   endtask

   // ---------------------------------------------------------------------------------------
   // Result sink: random stalls with quiet stretches where no new stall starts.
   // ---------------------------------------------------------------------------------------
   int unsigned stall_left = 0;
   int unsigned calm_left  = 0;

   always @(posedge clock) begin
      if (calm_left != 0) calm_left <= calm_left - 1;
      else if ($urandom_range(0, 999) < 4) calm_left <= $urandom_range(100, 400);
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (calm_left == 0 && $urandom_range(0, 99) < 35) stall_left <= idle_span();
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result checker: every accepted word against the oldest expectation.
   // ---------------------------------------------------------------------------------------
   scan_report_type want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_reports.size() == 0) begin
            $display("%0t: unexpected result: expected none, got found=%0b address=%h",
                     $time, rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            want = awaited_reports.pop_front();
            if (rsp_tuser !== want.found) begin
               $display("%0t: found mismatch: expected %0b, got %0b",
                        $time, want.found, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata !== want.addr) begin
               $display("%0t: match_address mismatch: expected %h, got %h",
                        $time, want.addr, rsp_tdata);
               fail_count++;
            end
         end
      end
   end

   // hard stop if the scanner hangs or loses a result
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------
   initial begin
      int unsigned  span;
      int unsigned  n;
      int unsigned  plant_at;
      int unsigned  lane;
      bit           plant;
      int unsigned  len_val;
      logic [63:0]  len_word;
      logic [127:0] mask_set;
      logic [127:0] pat_set;
      logic [63:0]  base_set;
      logic [7:0]   data;
      logic [7:0]   m;

      // register defaults after reset
      pat_lo    = '0;
      pat_hi    = '0;
      msk_lo    = '0;
      msk_hi    = '0;
      pat_len   = 5'd1;
      base_addr = '0;
      restart_range();

      // Directed table. Out of reset the mask is zero and the length one, so every byte
      // matches at offset 0 of its range.
      plan_known(8'hA5, 1'b0, 1'b0, 1'b1, 1'b1, '0);    // match on the first byte
      plan_known(8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, '0);    // after the match: silent, clears
      plan_known(8'h00, 1'b0, 1'b1, 1'b1, 1'b0, '0);    // read error ends the scan
      plan_known(8'h12, 1'b1, 1'b0, 1'b0, 1'b0, '0);    // silent tail after the error
      plan_known(8'h34, 1'b1, 1'b0, 1'b1, 1'b1, '0);    // match and last together
      plan_known(8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, '0);    // read error on the last byte
      // length zero acts as one; base at the top so the match address wraps
      plan_reg(CSR_PATTERN_LOW, 64'hF0E1_D2C3_B4A5_9680);
      plan_reg(CSR_PATTERN_HIGH, 64'h0123_4567_89AB_CDEF);
      plan_reg(CSR_MASK_LOW, ALL_ONES);
      plan_reg(CSR_MASK_HIGH, ALL_ONES);
      plan_reg(CSR_PATTERN_LENGTH, 64'd0);
      plan_reg(CSR_BASE_ADDRESS, ALL_ONES);
      plan_byte(8'h7F, 1'b0, 1'b0);
      plan_byte(8'h80, 1'b0, 1'b0);
      plan_byte(8'h00, 1'b1, 1'b0);
      plan_known(8'h00, 1'b1, 1'b0, 1'b1, 1'b0, '0);    // range over without a match
      // two-byte pattern with a false start
      plan_reg(CSR_PATTERN_LENGTH, 64'd2);
      plan_reg(CSR_BASE_ADDRESS, 64'h8000_0000_0000_0000);
      plan_byte(8'h80, 1'b0, 1'b0);
      plan_byte(8'h80, 1'b0, 1'b0);
      plan_byte(8'h96, 1'b0, 1'b0);
      plan_byte(8'h00, 1'b1, 1'b0);
      plan_known(8'h96, 1'b1, 1'b0, 1'b1, 1'b0, '0);    // window shorter than the pattern
      // length above the window size; a zero mask can never meet a nonzero pattern
      plan_reg(CSR_PATTERN_LENGTH, 64'd31);
      plan_reg(CSR_MASK_LOW, 64'd0);
      plan_reg(CSR_MASK_HIGH, 64'd0);
      plan_known(8'hAA, 1'b0, 1'b0, 1'b0, 1'b0, '0);
      plan_known(8'h55, 1'b1, 1'b0, 1'b1, 1'b0, '0);
      // unknown indexes are dropped; the length register keeps only its low five bits
      plan_reg(CSR_SPARE_6, ALL_ONES);
      plan_reg(CSR_SPARE_7, ALL_ONES);
      plan_reg(CSR_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE1);
      plan_reg(CSR_MASK_LOW, ALL_ONES);
      plan_byte(8'h80, 1'b0, 1'b0);
      plan_byte(8'h00, 1'b1, 1'b0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         if (plan[r].kind == ROW_REG)
            write_csr(plan[r].index, plan[r].value);
         else
            send_byte(plan[r].data, plan[r].last, plan[r].err,
                      plan[r].typed, plan[r].hit, plan[r].found, plan[r].addr);
      end

      // Random phases: new settings, then a handful of ranges with planted patterns,
      // some noise and an occasional full drain.
      while (sent_bytes < RANDOM_BYTES) begin
         case ($urandom_range(0, 5))
            0:       len_val = 1;
            1:       len_val = SCAN_SLOTS;
            2:       len_val = 0;
            3:       len_val = $urandom_range(17, 31);
            default: len_val = $urandom_range(2, 8);
         endcase
         len_word = ($urandom_range(0, 3) == 0) ? rand64() : '0;
         len_word[4:0] = len_val[4:0];

         case ($urandom_range(0, 3))
            0:       mask_set = '1;
            1:       mask_set = '0;
            default: begin
               for (int i = 0; i < SCAN_SLOTS; i++)
                  case ($urandom_range(0, 2))
                     0:       mask_set[i*8 +: 8] = 8'hFF;
                     1:       mask_set[i*8 +: 8] = 8'h00;
                     default: mask_set[i*8 +: 8] = 8'($urandom_range(0, 255));
                  endcase
            end
         endcase
         pat_set = {rand64(), rand64()};
         // mostly reachable patterns; a few with bits outside the mask never match
         if ($urandom_range(0, 4) != 0) pat_set &= mask_set;

         case ($urandom_range(0, 3))
            0:       base_set = '0;
            1:       base_set = ALL_ONES;
            2:       base_set = ALL_ONES - 64'($urandom_range(0, 40));
            default: base_set = rand64();
         endcase

         write_csr(CSR_PATTERN_LOW, pat_set[63:0]);
         write_csr(CSR_PATTERN_HIGH, pat_set[127:64]);
         write_csr(CSR_MASK_LOW, mask_set[63:0]);
         write_csr(CSR_MASK_HIGH, mask_set[127:64]);
         write_csr(CSR_PATTERN_LENGTH, len_word);
         write_csr(CSR_BASE_ADDRESS, base_set);
         if ($urandom_range(0, 7) == 0) write_csr(CSR_SPARE_6, rand64());
         if ($urandom_range(0, 7) == 0) write_csr(CSR_SPARE_7, rand64());

         sender_steady = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(2, 8)) begin
            case ($urandom_range(0, 19))
               0, 1: begin
                  // noise: stray bytes with random markers
                  repeat ($urandom_range(1, 10))
                     send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                               $urandom_range(0, 7) == 0, 1'b0, 1'b0, 1'b0, '0);
               end
               2: begin
                  // hold the stream until every outstanding result is back
                  csr_we     <= 1'b0;
                  req_tvalid <= 1'b0;
                  while (awaited_reports.size() != 0) @(posedge clock);
                  @(posedge clock);
               end
               default: begin
                  case ($urandom_range(0, 19))
                     0:             span = $urandom_range(65, 200);
                     1, 2, 3, 4, 5: span = $urandom_range(25, 64);
                     default:       span = $urandom_range(1, 24);
                  endcase
                  n        = live_length();
                  plant    = ($urandom_range(0, 2) != 0) && (span >= n);
                  plant_at = plant ? $urandom_range(0, span - n) : 0;
                  for (int k = 0; k < span; k++) begin
                     data = 8'($urandom_range(0, 255));
                     if (plant && k >= plant_at && k < plant_at + n) begin
                        lane = k - plant_at;
                        m    = mask_set[lane*8 +: 8];
                        data = (pat_set[lane*8 +: 8] & m) | (data & ~m);
                     end
                     send_byte(data, k == span - 1, $urandom_range(0, 99) == 0,
                               1'b0, 1'b0, 1'b0, '0);
                  end
               end
            endcase
         end
      end

      // drain and let the pipe settle before the verdict
      csr_we     <= 1'b0;
      req_tvalid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (2 * DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
